/* src/gbfp_pkg.sv */
// Package for the grid path search block.
// Types, opcodes, sequencer states, grid size and neighbour step tables; no dependencies.
package gbfp_pkg;

   localparam int CFG_W = 6;
   localparam int MAX_SIDE = 32;

   typedef enum logic [2:0] {
      KIND_BLOCK   = 3'd0,
      KIND_UNBLOCK = 3'd1,
      KIND_CLEAR   = 3'd2,
      KIND_SEARCH  = 3'd3,
      KIND_READ    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_DIAG   = 2'd2
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MAP_CLR,
      ST_INIT,
      ST_SCAN,
      ST_SCAN_END,
      ST_EXPAND,
      ST_TRACE,
      ST_TRACE_RD,
      ST_COPY,
      ST_COPY_WR,
      ST_DONE
   } state_type;

   // step order: (0,+1) (+1,0) (0,-1) (-1,0) (-1,-1) (+1,+1) (-1,+1) (+1,-1)
   function automatic logic signed [1:0] step_dx(input logic [2:0] d);
      case (d)
         3'd0: step_dx = 2'sd0;
         3'd1: step_dx = 2'sd1;
         3'd2: step_dx = 2'sd0;
         3'd3: step_dx = -2'sd1;
         3'd4: step_dx = -2'sd1;
         3'd5: step_dx = 2'sd1;
         3'd6: step_dx = -2'sd1;
         default: step_dx = 2'sd1;
      endcase
   endfunction

   function automatic logic signed [1:0] step_dy(input logic [2:0] d);
      case (d)
         3'd0: step_dy = 2'sd1;
         3'd1: step_dy = 2'sd0;
         3'd2: step_dy = -2'sd1;
         3'd3: step_dy = 2'sd0;
         3'd4: step_dy = -2'sd1;
         3'd5: step_dy = 2'sd1;
         3'd6: step_dy = 2'sd1;
         default: step_dy = -2'sd1;
      endcase
   endfunction

endpackage

/* src/grid_best_first_path_search.sv */
// Top level of the grid path search block: sequencer, cell memories, path store.
// Depends on gbfp_pkg and gbfp_heur.
//
// Usage: pulse start with a request while busy is low; one transaction is taken
// per request. The response appears for one cycle with rsp_valid high.
// Map edits, path reads and bad kinds: busy for one cycle in ST_DONE, and the
// response is registered from ST_DONE; the next start is taken while it shows.
// Clear all: busy while ST_MAP_CLR sweeps the whole map, then in ST_DONE.
// A search runs one open-set scan over the whole cell memory per closed cell,
// one cell per cycle through a single compare unit, then a read phase and a
// write phase in ST_EXPAND for each of the 4 or 8 neighbours. Path recovery
// steps through ST_TRACE and both ST_TRACE_RD phases per cell, then copies
// each cell through ST_COPY and ST_COPY_WR. After reset a clearing pass sweeps
// map and cell memory with busy high; csr writes are taken at any time (csr_ready is 1).
// The receiver cannot stall; each response is shown for exactly one cycle.
// Open/closed marks use an epoch counter per search; when the epoch wraps, a
// pass over all MAX_SIDE*MAX_SIDE cells clears the cell memory before that search.
module grid_best_first_path_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [4:0]  req_pos_x,
   input  logic [4:0]  req_pos_y,
   input  logic [4:0]  req_goal_x,
   input  logic [4:0]  req_goal_y,
   input  logic [9:0]  req_step_index,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [10:0] rsp_path_length,
   output logic [4:0]  rsp_cell_x,
   output logic [4:0]  rsp_cell_y,
   output logic        rsp_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);
   import gbfp_pkg::*;

   localparam int SB = $clog2(MAX_SIDE);
   localparam int CB = 2 * SB;
   localparam int NC = MAX_SIDE * MAX_SIDE;
   localparam int FW = SB + 6;
   localparam int PD = 1024;
   localparam int EW = 8;

   // configuration
   logic [5:0] width_ff, height_ff;
   logic       diag_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 6'd32;
         height_ff <= 6'd32;
         diag_ff   <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_DIAG:   diag_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [SB:0] w_side, h_side;
   always_comb begin
      w_side = (width_ff == 6'd0) ? (SB+1)'(1) :
               (32'(width_ff) > MAX_SIDE) ? (SB+1)'(MAX_SIDE) : (SB+1)'(width_ff);
      h_side = (height_ff == 6'd0) ? (SB+1)'(1) :
               (32'(height_ff) > MAX_SIDE) ? (SB+1)'(MAX_SIDE) : (SB+1)'(height_ff);
   end

   // memories: cell record = {epoch, closed, dir, f}
   logic           map_mem [NC];
   logic [EW+3+FW:0] cell_mem [NC];
   logic [CB-1:0]  path_mem [PD];

   logic           map_we, map_wd, map_q;
   logic [CB-1:0]  map_wa, map_ra;
   logic           cm_we;
   logic [CB-1:0]  cm_wa, cm_ra;
   logic [EW+3+FW:0] cm_wd, cm_q;
   logic           pm_we;
   logic [9:0]     pm_wa, pm_ra;
   logic [CB-1:0]  pm_wd, pm_q;

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      map_q <= map_mem[map_ra];
   end
   always_ff @(posedge clock) begin
      if (cm_we) cell_mem[cm_wa] <= cm_wd;
      cm_q <= cell_mem[cm_ra];
   end
   always_ff @(posedge clock) begin
      if (pm_we) path_mem[pm_wa] <= pm_wd;
      pm_q <= path_mem[pm_ra];
   end

   // trace buffer reuses cell memory index space
   logic [CB-1:0] tb_mem [NC];
   logic          tb_we;
   logic [CB-1:0] tb_wa, tb_ra, tb_wd, tb_q;
   always_ff @(posedge clock) begin
      if (tb_we) tb_mem[tb_wa] <= tb_wd;
      tb_q <= tb_mem[tb_ra];
   end

   // registers
   state_type      state_ff, state_in;
   logic [CB:0]    cnt_ff, cnt_in;
   logic [EW-1:0]  epoch_ff, epoch_in;
   logic           ep_wrap_ff, ep_wrap_in;
   logic [2:0]     kind_ff, kind_in;
   logic [SB-1:0]  sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [9:0]     step_ff, step_in;
   logic [10:0]    len_ff, len_in;
   logic           bvalid_ff, bvalid_in;
   logic [FW-1:0]  bf_ff, bf_in;
   logic [SB-1:0]  bx_ff, bx_in, by_ff, by_in;
   logic [SB-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [3:0]     d_ff, d_in;
   logic [CB:0]    n_ff, n_in;
   logic           ph_ff, ph_in;
   logic           rv_ff, rv_in, rf_ff, rf_in, re_ff, re_in;
   logic [10:0]    rl_ff, rl_in;
   logic [4:0]     rx_ff, rx_in, ry_ff, ry_in;

   // neighbour candidate and heuristic unit
   logic signed [SB+1:0] nxs, nys;
   logic signed [SB+1:0] txs, tys;
   logic [SB-1:0] nx, ny;
   logic          n_in_grid;
   logic [FW-1:0] f_nb;
   always_comb begin
      nxs = $signed({2'b00, bx_ff}) + (SB+2)'(step_dx(d_ff[2:0]));
      nys = $signed({2'b00, by_ff}) + (SB+2)'(step_dy(d_ff[2:0]));
      nx  = nxs[SB-1:0];
      ny  = nys[SB-1:0];
      n_in_grid = !nxs[SB+1] && !nys[SB+1] && (nxs < $signed({1'b0, w_side}))
                  && (nys < $signed({1'b0, h_side}));
   end
   gbfp_heur #(.CW(SB), .FW(FW)) u_heur (
      .cx(nx), .cy(ny), .ax(gx_ff), .ay(gy_ff), .bx(sx_ff), .by(sy_ff), .f(f_nb)
   );

   function automatic logic [CB-1:0] cidx(input logic [SB-1:0] x, input logic [SB-1:0] y);
      cidx = {y, x};
   endfunction

   logic          sc_live;
   logic [EW-1:0] q_ep;
   logic          q_cl;
   logic [2:0]    q_dir;
   logic [FW-1:0] q_f;
   logic          q_mine;
   always_comb begin
      {q_ep, q_cl, q_dir, q_f} = cm_q;
      q_mine = (q_ep == epoch_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         epoch_ff <= '0;
         ep_wrap_ff <= 1'b0;
         len_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         epoch_ff <= epoch_in;
         ep_wrap_ff <= ep_wrap_in;
         len_ff   <= len_in;
         rv_ff    <= rv_in;
      end
      kind_ff <= kind_in; sx_ff <= sx_in; sy_ff <= sy_in; gx_ff <= gx_in; gy_ff <= gy_in;
      step_ff <= step_in; bvalid_ff <= bvalid_in; bf_ff <= bf_in; bx_ff <= bx_in;
      by_ff <= by_in; cx_ff <= cx_in; cy_ff <= cy_in; d_ff <= d_in; n_ff <= n_in;
      ph_ff <= ph_in; rf_ff <= rf_in; re_ff <= re_in; rl_ff <= rl_in;
      rx_ff <= rx_in; ry_ff <= ry_in;
   end

   logic nb_ok;
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; epoch_in = epoch_ff; ep_wrap_in = ep_wrap_ff;
      kind_in = kind_ff; sx_in = sx_ff; sy_in = sy_ff; gx_in = gx_ff; gy_in = gy_ff;
      step_in = step_ff; len_in = len_ff; bvalid_in = bvalid_ff; bf_in = bf_ff;
      bx_in = bx_ff; by_in = by_ff; cx_in = cx_ff; cy_in = cy_ff; d_in = d_ff;
      n_in = n_ff; ph_in = ph_ff;
      rv_in = 1'b0; rf_in = rf_ff; re_in = re_ff; rl_in = rl_ff; rx_in = rx_ff; ry_in = ry_ff;
      map_we = 1'b0; map_wa = '0; map_wd = 1'b0; map_ra = '0;
      cm_we = 1'b0; cm_wa = '0; cm_wd = '0; cm_ra = '0;
      pm_we = 1'b0; pm_wa = '0; pm_wd = '0; pm_ra = step_ff;
      tb_we = 1'b0; tb_wa = '0; tb_wd = '0; tb_ra = '0;
      txs = '0; tys = '0;
      sc_live = 1'b0; nb_ok = 1'b0;
      busy = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               sx_in = SB'(req_pos_x); sy_in = SB'(req_pos_y);
               gx_in = SB'(req_goal_x); gy_in = SB'(req_goal_y);
               step_in = req_step_index;
               rf_in = 1'b0; rl_in = '0; rx_in = '0; ry_in = '0; re_in = 1'b0;
               case (req_kind)
                  KIND_BLOCK, KIND_UNBLOCK: begin
                     if ((6'(req_pos_x) >= 6'(w_side)) || (6'(req_pos_y) >= 6'(h_side)))
                        re_in = 1'b1;
                     else begin
                        map_we = 1'b1;
                        map_wa = cidx(SB'(req_pos_x), SB'(req_pos_y));
                        map_wd = (req_kind == KIND_BLOCK);
                     end
                     state_in = ST_DONE;
                  end
                  KIND_CLEAR: begin
                     cnt_in = '0; state_in = ST_MAP_CLR;
                  end
                  KIND_SEARCH: begin
                     if ((6'(req_pos_x) >= 6'(w_side)) || (6'(req_pos_y) >= 6'(h_side)) ||
                         (6'(req_goal_x) >= 6'(w_side)) || (6'(req_goal_y) >= 6'(h_side))) begin
                        re_in = 1'b1; len_in = '0; state_in = ST_DONE;
                     end else begin
                        len_in = '0;
                        epoch_in = epoch_ff + 1'b1;
                        map_ra = cidx(SB'(req_goal_x), SB'(req_goal_y));
                        if (epoch_ff == {EW{1'b1}}) begin
                           ep_wrap_in = 1'b1; cnt_in = '0; state_in = ST_CLEAR;
                        end else state_in = ST_INIT;
                        ph_in = 1'b0;
                     end
                  end
                  KIND_READ: begin
                     pm_ra = req_step_index;
                     state_in = ST_DONE;
                  end
                  default: begin
                     re_in = 1'b1; state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            // wipes stale epoch marks in cell memory; map too after reset
            cm_we = 1'b1; cm_wa = cnt_ff[CB-1:0]; cm_wd = '0;
            if (!ep_wrap_ff) begin
               map_we = 1'b1; map_wa = cnt_ff[CB-1:0]; map_wd = 1'b0;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (CB+1)'(NC-1)) begin
               if (ep_wrap_ff) begin
                  ep_wrap_in = 1'b0; epoch_in = EW'(1);
                  map_ra = cidx(gx_ff, gy_ff);
                  state_in = ST_INIT;
               end else begin
                  epoch_in = '0; state_in = ST_IDLE;
               end
            end
         end
         ST_MAP_CLR: begin
            map_we = 1'b1; map_wa = cnt_ff[CB-1:0]; map_wd = 1'b0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (CB+1)'(NC-1)) state_in = ST_DONE;
         end
         ST_INIT: begin
            // map_q holds the goal cell
            map_ra = cidx(gx_ff, gy_ff);
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (map_q) begin
               rf_in = 1'b0; rl_in = '0; state_in = ST_DONE;
            end else begin
               cm_we = 1'b1; cm_wa = cidx(sx_ff, sy_ff);
               bx_in = gx_ff; by_in = gy_ff;
               cm_wd = {epoch_ff, 1'b0, 3'd0, FW'(0)};
               // source is the only open cell, so its f never takes part in a compare
               cnt_in = '0; bvalid_in = 1'b0; state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read cell cnt, compare cell cnt-1 (registered read)
            cm_ra = cnt_ff[CB-1:0];
            if (cnt_ff != '0) begin
               sc_live = q_mine && !q_cl &&
                         ((CB+1)'(n_ff[SB-1:0]) < (CB+1)'(w_side)) &&
                         ((CB+1)'(n_ff[CB-1:SB]) < (CB+1)'(h_side));
               if (sc_live && (!bvalid_ff || q_f < bf_ff)) begin
                  bvalid_in = 1'b1; bf_in = q_f;
                  bx_in = n_ff[SB-1:0]; by_in = n_ff[CB-1:SB];
               end
            end
            n_in = cnt_ff;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (CB+1)'(NC)) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: begin
            if (!bvalid_ff) begin
               rf_in = 1'b0; rl_in = '0; state_in = ST_DONE;
            end else begin
               cm_ra = cidx(bx_ff, by_ff);
               d_in = 4'd0; ph_in = 1'b0;
               if (bx_ff == gx_ff && by_ff == gy_ff) begin
                  cx_in = gx_ff; cy_in = gy_ff; n_in = '0; state_in = ST_TRACE;
               end else state_in = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            // phase 0: close best (first direction only), issue reads; phase 1: write neighbour if new
            if (!ph_ff) begin
               if (d_ff == 4'd0) begin
                  cm_we = 1'b1; cm_wa = cidx(bx_ff, by_ff);
                  cm_wd = {epoch_ff, 1'b1, q_dir, q_f};
               end
               cm_ra = cidx(nx, ny); map_ra = cidx(nx, ny);
               ph_in = 1'b1;
            end else begin
               nb_ok = n_in_grid && !map_q && !q_mine;
               if (nb_ok) begin
                  cm_we = 1'b1; cm_wa = cidx(nx, ny);
                  cm_wd = {epoch_ff, 1'b0, d_ff[2:0], f_nb};
               end
               ph_in = 1'b0;
               d_in = d_ff + 1'b1;
               if (d_ff == (diag_ff ? 4'd7 : 4'd3)) begin
                  cnt_in = '0; bvalid_in = 1'b0; state_in = ST_SCAN;
               end
            end
         end
         ST_TRACE: begin
            tb_we = 1'b1; tb_wa = n_ff[CB-1:0]; tb_wd = cidx(cx_ff, cy_ff);
            n_in = n_ff + 1'b1;
            if ((cx_ff == sx_ff && cy_ff == sy_ff) || (n_ff == (CB+1)'(NC-1))) begin
               cnt_in = '0; state_in = ST_COPY;
               len_in = (n_ff + 1'b1 > (CB+1)'(PD)) ? 11'(PD) : 11'(n_ff + 1'b1);
            end else begin
               cm_ra = cidx(cx_ff, cy_ff);
               state_in = ST_TRACE_RD;
               ph_in = 1'b0;
            end
         end
         ST_TRACE_RD: begin
            if (!ph_ff) ph_in = 1'b1;
            else begin
               txs = $signed({2'b00, cx_ff}) - (SB+2)'(step_dx(q_dir));
               tys = $signed({2'b00, cy_ff}) - (SB+2)'(step_dy(q_dir));
               if (txs[SB+1] || tys[SB+1] || txs >= $signed({1'b0, w_side})
                   || tys >= $signed({1'b0, h_side})) begin
                  cnt_in = '0; state_in = ST_COPY;
                  len_in = (n_ff > (CB+1)'(PD)) ? 11'(PD) : 11'(n_ff);
               end else begin
                  cx_in = txs[SB-1:0]; cy_in = tys[SB-1:0]; state_in = ST_TRACE;
               end
            end
            cm_ra = cidx(cx_ff, cy_ff);
         end
         ST_COPY: begin
            tb_ra = CB'(n_ff - 1'b1 - cnt_ff);
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            pm_we = 1'b1; pm_wa = cnt_ff[9:0]; pm_wd = tb_q;
            cnt_in = cnt_ff + 1'b1;
            if ((cnt_ff + 1'b1) == (CB+1)'(len_ff)) begin
               rf_in = 1'b1; rl_in = len_ff; state_in = ST_DONE;
            end else state_in = ST_COPY;
         end
         ST_DONE: begin
            if (kind_ff == KIND_READ) begin
               rf_in = (len_ff != '0); rl_in = len_ff;
               if (11'(step_ff) >= len_ff) re_in = 1'b1;
               else begin
                  rx_in = 5'(pm_q[SB-1:0]); ry_in = 5'(pm_q[CB-1:SB]);
               end
            end
            rv_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_found = rf_ff;
   assign rsp_path_length = rl_ff;
   assign rsp_cell_x = rx_ff;
   assign rsp_cell_y = ry_ff;
   assign rsp_error = re_ff;

   a_one_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response held two cycles");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid && !busy) else $error("done without response");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_path_length <= 11'(PD)) else $error("path length overflow");
   a_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> rsp_path_length != '0) else $error("found without path");

endmodule

/* src/gbfp_heur.sv */
// Heuristic unit: 10*(|dx|+|dy|) summed against goal and source.
// Depends on gbfp_pkg.
module gbfp_heur #(
   parameter int CW = 5,
   parameter int FW = 14
) (
   input  logic [CW-1:0] cx,
   input  logic [CW-1:0] cy,
   input  logic [CW-1:0] ax,
   input  logic [CW-1:0] ay,
   input  logic [CW-1:0] bx,
   input  logic [CW-1:0] by,
   output logic [FW-1:0] f
);
   import gbfp_pkg::*;
   logic [CW-1:0] d0, d1, d2, d3;
   logic [CW+2:0] s;
   always_comb begin
      d0 = (cx > ax) ? cx - ax : ax - cx;
      d1 = (cy > ay) ? cy - ay : ay - cy;
      d2 = (cx > bx) ? cx - bx : bx - cx;
      d3 = (cy > by) ? cy - by : by - cy;
      s = (CW+3)'(d0) + (CW+3)'(d1) + (CW+3)'(d2) + (CW+3)'(d3);
      f = FW'(({s, 3'b000}) + ({s, 1'b0}));
   end
endmodule
